@@ rtl/hs_pkg.sv @@
// ----------------------------------------------------------------------------
// hs_pkg: shared constants and types for the heap sorter
// Word width, default store depth and the element word type.
// ----------------------------------------------------------------------------
package hs_pkg;

  // width of one element word
  localparam int WORD_W = 32;

  // default number of store entries
  localparam int DEPTH_DEF = 64;

  // one element word, compared as two's complement
  typedef logic signed [WORD_W-1:0] word_t;

endpackage

@@ rtl/heap_sorter.sv @@
// A word without in_last is taken while idle. A word with in_last starts an
//   in-place heap sort of the n stored words (a bottom-up build of sift
//   levels, then extraction steps that each sift from the root), after
//   which the n results are read out.
// Throughput is set by the single read port; results are never held off.
// Reset clears the state, count and overflow flag; the store is not cleared.
// ----------------------------------------------------------------------------
// heap_sorter: collects a list of signed words and returns them sorted
// Words go into a one-port-read, one-port-write store. On the last word the
// store is heap-sorted in place (bottom-up build, then root extraction) and
// read out in ascending order, one word per cycle on a strobe.
// ----------------------------------------------------------------------------
module heap_sorter #(
  parameter int DEPTH = hs_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hs_pkg::word_t       in_value,
  input  logic                in_last,
  output logic                out_valid,
  output hs_pkg::word_t       out_sorted_value,
  output logic                out_final_res,
  output logic                out_overflow
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // state codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BLD  = 4'd1;  // next build-phase node
  localparam logic [3:0] S_LDN  = 4'd2;  // node word arrives
  localparam logic [3:0] S_SDL  = 4'd3;  // issue left child read
  localparam logic [3:0] S_SDR  = 4'd4;  // left arrives, issue right read
  localparam logic [3:0] S_SDC  = 4'd5;  // right arrives, decide
  localparam logic [3:0] S_SRT  = 4'd6;  // next extraction step
  localparam logic [3:0] S_SW1  = 4'd7;  // root arrives
  localparam logic [3:0] S_SW2  = 4'd8;  // tail arrives, swap
  localparam logic [3:0] S_OUT  = 4'd9;  // read out ascending

  logic [3:0]     state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           ovf_r, ovf_nxt;
  logic           phase_r, phase_nxt;     // 0 build, 1 extraction
  logic           oval_r, oval_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  size_r, size_nxt;
  logic [CW-1:0]  node_r, node_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  hs_pkg::word_t  nv_r, nv_nxt;           // word being sifted (the hole's value)
  hs_pkg::word_t  lv_r, lv_nxt;           // left child or saved root
  logic           ofin_r, ofin_nxt;
  logic           oovf_r, oovf_nxt;

  // element store
  hs_pkg::word_t  mem [DEPTH];
  hs_pkg::word_t  rd_data_r;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  hs_pkg::word_t  wr_data;

  logic [CW:0]    left_w, right_w;
  logic [CW-1:0]  cnt_inc;
  logic [3:0]     ret_state;
  logic           left_gt, right_gt_top;
  hs_pkg::word_t  top_val;

  assign left_w    = {node_r, 1'b1};
  assign right_w   = left_w + (CW+1)'(1);
  assign cnt_inc   = cnt_r + CW'(1);
  assign ret_state = phase_r ? S_SRT : S_BLD;

  // child compares: left must beat the node, right must beat the larger
  assign left_gt      = lv_r > nv_r;
  assign top_val      = left_gt ? lv_r : nv_r;
  assign right_gt_top = rd_data_r > top_val;

  // store: a read in the same cycle as a write to that entry returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    phase_nxt = phase_r;
    oval_nxt  = 1'b0;
    idx_nxt   = idx_r;
    size_nxt  = size_r;
    node_nxt  = node_r;
    k_nxt     = k_r;
    nv_nxt    = nv_r;
    lv_nxt    = lv_r;
    ofin_nxt  = 1'b0;
    oovf_nxt  = oovf_r;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = cnt_r[AW-1:0];
    wr_data   = in_value;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (cnt_r < DEPTH_C) begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_inc;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            idx_nxt   = cnt_nxt >> 1;
            state_nxt = S_BLD;
          end
        end
      end

      S_BLD: begin
        if (idx_r == '0) begin
          idx_nxt   = cnt_r - CW'(1);
          state_nxt = S_SRT;
        end else begin
          rd_addr   = AW'(idx_r - CW'(1));
          node_nxt  = idx_r - CW'(1);
          idx_nxt   = idx_r - CW'(1);
          size_nxt  = cnt_r;
          phase_nxt = 1'b0;
          state_nxt = S_LDN;
        end
      end

      S_LDN: begin
        nv_nxt    = rd_data_r;
        state_nxt = S_SDL;
      end

      S_SDL: begin
        if (left_w < {1'b0, size_r}) begin
          rd_addr   = left_w[AW-1:0];
          state_nxt = S_SDR;
        end else begin
          // leaf: drop the word into the hole
          wr_en     = 1'b1;
          wr_addr   = node_r[AW-1:0];
          wr_data   = nv_r;
          state_nxt = ret_state;
        end
      end

      S_SDR: begin
        lv_nxt = rd_data_r;
        if (right_w < {1'b0, size_r}) begin
          rd_addr   = right_w[AW-1:0];
          state_nxt = S_SDC;
        end else begin
          wr_en   = 1'b1;
          wr_addr = node_r[AW-1:0];
          if (rd_data_r > nv_r) begin
            wr_data   = rd_data_r;
            node_nxt  = left_w[CW-1:0];
            state_nxt = S_SDL;
          end else begin
            wr_data   = nv_r;
            state_nxt = ret_state;
          end
        end
      end

      S_SDC: begin
        wr_en   = 1'b1;
        wr_addr = node_r[AW-1:0];
        if (right_gt_top) begin
          wr_data   = rd_data_r;
          node_nxt  = right_w[CW-1:0];
          state_nxt = S_SDL;
        end else if (left_gt) begin
          wr_data   = lv_r;
          node_nxt  = left_w[CW-1:0];
          state_nxt = S_SDL;
        end else begin
          wr_data   = nv_r;
          state_nxt = ret_state;
        end
      end

      S_SRT: begin
        if (idx_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_OUT;
        end else begin
          rd_addr   = '0;
          phase_nxt = 1'b1;
          state_nxt = S_SW1;
        end
      end

      S_SW1: begin
        lv_nxt    = rd_data_r;
        rd_addr   = idx_r[AW-1:0];
        state_nxt = S_SW2;
      end

      // max goes to the tail, old tail sifts down from the root
      S_SW2: begin
        nv_nxt    = rd_data_r;
        wr_en     = 1'b1;
        wr_addr   = idx_r[AW-1:0];
        wr_data   = lv_r;
        size_nxt  = idx_r;
        node_nxt  = '0;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = S_SDL;
      end

      S_OUT: begin
        rd_addr  = k_r[AW-1:0];
        oval_nxt = 1'b1;
        ofin_nxt = (k_r == cnt_r - CW'(1));
        oovf_nxt = ovf_r;
        k_nxt    = k_r + CW'(1);
        if (k_r == cnt_r - CW'(1)) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      phase_r <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      phase_r <= phase_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    size_r <= size_nxt;
    node_r <= node_nxt;
    k_r    <= k_nxt;
    nv_r   <= nv_nxt;
    lv_r   <= lv_nxt;
    ofin_r <= ofin_nxt;
    oovf_r <= oovf_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = oval_r;
  assign out_sorted_value = rd_data_r;
  assign out_final_res    = ofin_r;
  assign out_overflow     = oovf_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("element count beyond store depth");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last |=> busy)
    else $error("list end did not start the sort");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_res |=> !out_valid)
    else $error("result after the final word");

  a_node_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SDL || state_r == S_SDR || state_r == S_SDC) |->
      (node_r < size_r && size_r <= cnt_r))
    else $error("sift node outside the heap");

  a_out_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> (k_r < cnt_r && !out_final_res))
    else $error("readout past the list");

endmodule

@@ tb/heap_sorter_test.sv @@
// ----------------------------------------------------------------------------
// heap_sorter_test: self-checking bench for the heap sorter
// Feeds lists of signed words through the start/busy port and scores every
// strobed result against an in-bench heap sort of the same list. A short
// directed table comes first (single-word lists at the extremes, duplicates,
// mixed signs), then random lists with one store-filling list and one list
// that overruns the store. The sender idles at random between words.
// ----------------------------------------------------------------------------
module heap_sorter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = hs_pkg::DEPTH_DEF;

  typedef hs_pkg::word_t word_t;

  localparam word_t WORD_MAX = 32'sh7fff_ffff;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  // one sorted word as it leaves the block
  typedef struct packed {
    word_t value;
    logic  fin;
    logic  ovf;
  } sorted_word_t;

  // one row of directed stimulus; exp holds a typed-in result when known
  typedef struct packed {
    word_t        value;
    logic         last;
    logic         known;
    sorted_word_t exp;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  word_t in_value = '0;
  logic  in_last = 1'b0;
  logic  out_valid;
  word_t out_sorted_value;
  logic  out_final_res;
  logic  out_overflow;

  // in-bench copy of the list store
  word_t held_words [DEPTH];
  int    held_count = 0;
  bit    dropped_seen = 1'b0;

  sorted_word_t fresh_sorted[$];
  sorted_word_t awaited_sorted[$];
  stim_row_t    dir_rows[$];
  int           mismatch_count = 0;
  int           words_sent = 0;

  always #4 clk = ~clk;

  heap_sorter #(.DEPTH(DEPTH)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_overflow     (out_overflow)
  );

  // push the word at node down a max-heap of size entries
  function automatic void sift_held(int size, int node);
    int    top;
    int    lc;
    int    rc;
    word_t t;
    bit    done;
    done = 1'b0;
    while (!done && node < size) begin
      top = node;
      lc  = 2 * node + 1;
      rc  = 2 * node + 2;
      if (lc < size && held_words[lc] > held_words[top]) top = lc;
      if (rc < size && held_words[rc] > held_words[top]) top = rc;
      if (top == node) begin
        done = 1'b1;
      end else begin
        t                = held_words[node];
        held_words[node] = held_words[top];
        held_words[top]  = t;
        node             = top;
      end
    end
  endfunction

  // store one word; on the last word heap-sort and queue the sorted list
  function automatic void take_word(word_t v, logic l);
    int           n;
    word_t        t;
    sorted_word_t r;
    if (held_count < DEPTH) begin
      held_words[held_count] = v;
      held_count++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (l) begin
      n = held_count;
      for (int i = n / 2; i > 0; i--) sift_held(n, i - 1);
      for (int i = n - 1; i > 0; i--) begin
        t             = held_words[0];
        held_words[0] = held_words[i];
        held_words[i] = t;
        sift_held(i, 0);
      end
      for (int k = 0; k < n; k++) begin
        r.value = held_words[k];
        r.fin   = (k == n - 1);
        r.ovf   = dropped_seen;
        fresh_sorted.push_back(r);
      end
      held_count   = 0;
      dropped_seen = 1'b0;
    end
  endfunction

  function automatic stim_row_t row(word_t v, logic l, logic known, word_t ev);
    stim_row_t r;
    r.value     = v;
    r.last      = l;
    r.known     = known;
    r.exp.value = ev;
    r.exp.fin   = 1'b1;
    r.exp.ovf   = 1'b0;
    return r;
  endfunction

  // random word: full range, small values for duplicates, or near the extremes
  function automatic word_t rand_word();
    word_t w;
    case ($urandom_range(0, 5))
      3: begin
        w = $urandom_range(0, 16);
        w = w - 8;
      end
      4: begin
        case ($urandom_range(0, 3))
          0: w = WORD_MAX;
          1: w = WORD_MIN;
          2: w = '0;
          default: w = '1;
        endcase
      end
      5: w = $urandom_range(0, 1) ? WORD_MAX - $urandom_range(0, 3)
                                  : WORD_MIN + $urandom_range(0, 3);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // sender gap; a quiet window in the middle has none
  task automatic pause_sender();
    if (!(words_sent >= 120 && words_sent < 175) && $urandom_range(0, 99) < 37) begin
      start <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(8, 30)) @(posedge clk);
      else repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // drive one word, wait for it to be taken, then queue what it should yield
  task automatic send_word(stim_row_t r);
    in_value <= r.value;
    in_last  <= r.last;
    start    <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    take_word(r.value, r.last);
    if (r.known) awaited_sorted.push_back(r.exp);
    else foreach (fresh_sorted[i]) awaited_sorted.push_back(fresh_sorted[i]);
    fresh_sorted.delete();
  endtask

  // score every strobed word against the oldest one awaited
  always @(posedge clk) begin : score_sorted
    sorted_word_t want;
    if (rst_n && out_valid) begin
      if (awaited_sorted.size() == 0) begin
        $display("%0t: unexpected word value %0d final %0b overflow %0b", $time,
                 out_sorted_value, out_final_res, out_overflow);
        mismatch_count++;
      end else begin
        want = awaited_sorted.pop_front();
        if (out_sorted_value !== want.value) begin
          $display("%0t: sorted_value expected %0d actual %0d", $time,
                   want.value, out_sorted_value);
          mismatch_count++;
        end
        if (out_final_res !== want.fin) begin
          $display("%0t: final_res expected %0b actual %0b", $time,
                   want.fin, out_final_res);
          mismatch_count++;
        end
        if (out_overflow !== want.ovf) begin
          $display("%0t: overflow expected %0b actual %0b", $time,
                   want.ovf, out_overflow);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus
  initial begin : drive_lists
    int list_no;
    int len;
    int rand_goal;
    stim_row_t r;

    // single-word lists at the extremes: the word comes straight back
    dir_rows.push_back(row(WORD_MAX, 1'b1, 1'b1, WORD_MAX));
    dir_rows.push_back(row(WORD_MIN, 1'b1, 1'b1, WORD_MIN));
    dir_rows.push_back(row('0, 1'b1, 1'b1, '0));
    dir_rows.push_back(row('1, 1'b1, 1'b1, '1));
    dir_rows.push_back(row(32'sd1, 1'b1, 1'b1, 32'sd1));
    // two words in reverse order
    dir_rows.push_back(row(32'sd5, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(-32'sd5, 1'b1, 1'b0, '0));
    // mixed signs and extremes, minimum twice
    dir_rows.push_back(row(WORD_MAX, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(WORD_MIN, 1'b0, 1'b0, '0));
    dir_rows.push_back(row('0, 1'b0, 1'b0, '0));
    dir_rows.push_back(row('1, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(32'sd1, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(WORD_MIN, 1'b1, 1'b0, '0));
    // all equal
    dir_rows.push_back(row(32'sd7, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(32'sd7, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(32'sd7, 1'b1, 1'b0, '0));
    // alternating bit patterns
    dir_rows.push_back(row(32'sh5555_5555, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(32'shaaaa_aaaa, 1'b1, 1'b0, '0));
    // already ascending
    dir_rows.push_back(row(32'sd1, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(32'sd2, 1'b0, 1'b0, '0));
    dir_rows.push_back(row(32'sd3, 1'b1, 1'b0, '0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      pause_sender();
      send_word(dir_rows[i]);
    end

    // random lists; one fills the store exactly, one overruns it
    list_no   = 0;
    rand_goal = words_sent + 190;
    while (words_sent < rand_goal) begin
      if (list_no == 3) len = DEPTH;
      else if (list_no == 9) len = DEPTH + $urandom_range(2, 3);
      else len = $urandom_range(1, 10);
      for (int j = 0; j < len; j++) begin
        pause_sender();
        r = row(rand_word(), j == len - 1, 1'b0, '0);
        send_word(r);
      end
      list_no++;
    end
    start <= 1'b0;

    // drain
    while (awaited_sorted.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** heap_sorter: PASSED **");
    end else begin
      $display("** heap_sorter: FAILED **");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("** heap_sorter: FAILED **");
    $finish;
  end

endmodule
